// ===== src/cpsp_pkg.sv =====
// Shared types, constants and arithmetic helpers of the capture point step planner.
package cpsp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 24;
    localparam logic signed [25:0] PELVIS_COM_OFFSET = 26'sd5120;
    localparam logic [15:0] INV_OMEGA_RST = 16'd9362;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [2:0] REG_INV_OMEGA = 3'd0;
    localparam logic [2:0] REG_FWD_BIAS = 3'd1;
    localparam logic [2:0] REG_LAT_BASE = 3'd2;
    localparam logic [2:0] REG_LAT_SPEED = 3'd3;
    localparam logic [2:0] REG_HIP_OFFSET = 3'd4;

    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_LEFT = 2'd2;

    localparam int MAC_AW = 32;
    localparam int MAC_BW = 18;
    localparam int ACC_W = 48;

    typedef struct packed {
        logic start;
        logic clr;
    } t_mac_req;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0: v = 34'sh03243F6A8;
            5'd1: v = 34'sh01DAC6705;
            5'd2: v = 34'sh00FADBAFC;
            5'd3: v = 34'sh007F56EA6;
            5'd4: v = 34'sh003FEAB76;
            5'd5: v = 34'sh001FFD55B;
            5'd6: v = 34'sh000FFFAAA;
            5'd7: v = 34'sh0007FFF55;
            5'd8: v = 34'sh0003FFFEA;
            5'd9: v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up by 2^15
    function automatic logic signed [32:0] rnd15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_W'(16384)) >>> 15;
        return t[32:0];
    endfunction

    function automatic logic signed [31:0] rnd16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_W'(32768)) >>> 16;
        return t[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        logic signed [23:0] r;
        if (v > 36'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -36'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== src/cpsp_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine in Q15, one step per cycle.
module cpsp_cordic #(
    parameter int CORDIC_STEPS = cpsp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [15:0]        i_angle,
    output logic                      o_done,
    output logic signed [17:0]        o_cos,
    output logic signed [17:0]        o_sin
);
    import cpsp_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [IW-1:0]     r_i;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] z0, x_sh, y_sh, ang;
    logic signed [33:0] tx, ty;

    always_comb begin
        z0 = 34'(i_angle) <<< 16;
        x_sh = r_x >>> r_i;
        y_sh = r_y >>> r_i;
        ang = atan_q30(5'(r_i));
        tx = (r_x + 34'sd16384) >>> 15;
        ty = (r_y + 34'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (z0 > HALF_PI_Q30) begin
                r_z <= z0 - HALF_PI_Q30;
                r_x <= '0;
                r_y <= GAIN_Q30;
            end else if (z0 < -HALF_PI_Q30) begin
                r_z <= z0 + HALF_PI_Q30;
                r_x <= '0;
                r_y <= -GAIN_Q30;
            end else begin
                r_z <= z0;
                r_x <= GAIN_Q30;
                r_y <= '0;
            end
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos = tx[17:0];
    assign o_sin = ty[17:0];

endmodule

// ===== src/cpsp_smac.sv =====
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
module cpsp_smac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cpsp_pkg::t_mac_req                 i_req,
    input  logic signed [cpsp_pkg::MAC_AW-1:0] i_a,
    input  logic signed [cpsp_pkg::MAC_BW-1:0] i_b,
    output logic                               o_done,
    output logic signed [cpsp_pkg::ACC_W-1:0]  o_acc
);
    import cpsp_pkg::*;

    localparam int CW = $clog2(MAC_BW);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic signed [ACC_W-1:0] r_a;
    logic [MAC_BW-1:0]       r_b;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] term;
    logic                    last;

    assign term = r_b[0] ? r_a : '0;
    assign last = (r_cnt == CW'(MAC_BW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // top multiplier bit carries negative weight
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= ACC_W'(i_a);
            r_b <= i_b;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= last ? r_acc - term : r_acc + term;
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_acc = r_acc;

endmodule

// ===== src/capture_point_step_planner.sv =====
// Top level of the capture point step planner: sequencer, registers and stream ports.
// A request runs from acceptance to the next acceptance through two CORDIC runs for roll
// and pitch, one iteration a cycle, then twelve products on one bit-serial multiply-accumulate
// unit, each started, stepped through the multiplier bits and awaited, with control states for
// the capture point sum, the foot offsets and the output in between.
// One request is worked at a time; the next is taken while a finished result still waits
// in the output register, and the one after that stalls until the output register is free.
// Configuration writes land at once and must come while idle.
module capture_point_step_planner #(
    parameter int CORDIC_STEPS = cpsp_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // foot_x[23:0], foot_y[47:24], foot_z[71:48], roll[87:72], pitch[103:88]
    input  logic [103:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // step_x[23:0], step_y[47:24]
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data
);
    import cpsp_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TRIG_R = 5'd1;
    localparam logic [4:0] S_TRIG_RW = 5'd2;
    localparam logic [4:0] S_TRIG_P = 5'd3;
    localparam logic [4:0] S_TRIG_PW = 5'd4;
    localparam logic [4:0] S_M_RP = 5'd5;
    localparam logic [4:0] S_M_PR = 5'd6;
    localparam logic [4:0] S_CX0 = 5'd7;
    localparam logic [4:0] S_CX1 = 5'd8;
    localparam logic [4:0] S_CX2 = 5'd9;
    localparam logic [4:0] S_CY0 = 5'd10;
    localparam logic [4:0] S_CY1 = 5'd11;
    localparam logic [4:0] S_VX = 5'd12;
    localparam logic [4:0] S_VY = 5'd13;
    localparam logic [4:0] S_CAPY = 5'd14;
    localparam logic [4:0] S_FXY = 5'd15;
    localparam logic [4:0] S_UX0 = 5'd16;
    localparam logic [4:0] S_UX1 = 5'd17;
    localparam logic [4:0] S_UY = 5'd18;
    localparam logic [4:0] S_OUT = 5'd19;
    localparam logic [4:0] S_WAIT = 5'd20;

    logic [4:0] r_state, n_state, r_ret, n_ret;

    logic [15:0]        r_inv_omega;
    logic signed [23:0] r_fwd_bias, r_lat_base, r_lat_speed;
    logic [22:0]        r_hip;
    logic signed [23:0] r_prev_x, r_prev_y;

    logic signed [23:0] r_fxi, r_fyi;
    logic signed [15:0] r_roll, r_pitch;
    logic [1:0]         r_kind;
    logic signed [25:0] r_x, r_y, r_z;
    logic signed [17:0] r_cr, r_sr, r_cp, r_sp, r_srsp, r_spcr;
    logic signed [23:0] r_comx, r_comy;
    logic signed [26:0] r_capx, r_capy;
    logic signed [29:0] r_fx, r_fy;
    logic signed [23:0] r_ux;
    logic               r_ovalid;
    logic [47:0]        r_odata;

    logic               cor_start, cor_done;
    logic signed [15:0] cor_angle;
    logic signed [17:0] cor_cos, cor_sin;

    t_mac_req                 mac_req;
    logic signed [MAC_AW-1:0] mac_a;
    logic signed [MAC_BW-1:0] mac_b;
    logic                     mac_done;
    logic signed [ACC_W-1:0]  mac_acc;

    logic               right, left, accept;
    logic signed [32:0] acc_r15;
    logic signed [31:0] acc_r16;
    logic signed [25:0] hip_half, in_y, lat_bias;
    logic signed [23:0] in_fx, in_fy, in_fz;
    logic signed [35:0] uy_sum;
    logic signed [24:0] hip_s;

    cpsp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    cpsp_smac u_smac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    assign in_fx = s_axis_tdata[23:0];
    assign in_fy = s_axis_tdata[47:24];
    assign in_fz = s_axis_tdata[71:48];
    assign right = (r_kind == KIND_RIGHT);
    assign left = (r_kind == KIND_LEFT);
    assign acc_r15 = rnd15(mac_acc);
    assign acc_r16 = rnd16(mac_acc);

    always_comb begin
        hip_half = 26'({1'b0, r_hip[22:1]});
        if (s_axis_tuser == KIND_RIGHT) begin
            in_y = -(26'(in_fy) + hip_half);
        end else if (s_axis_tuser == KIND_LEFT) begin
            in_y = -(26'(in_fy) - hip_half);
        end else begin
            in_y = -26'(in_fy);
        end
        if (right) begin
            lat_bias = 26'(r_lat_base) - 26'(r_lat_speed);
            hip_s = 25'({1'b0, r_hip});
        end else if (left) begin
            lat_bias = -(26'(r_lat_base) + 26'(r_lat_speed));
            hip_s = -25'({1'b0, r_hip});
        end else begin
            lat_bias = '0;
            hip_s = '0;
        end
        uy_sum = 36'(acc_r15) + 36'(hip_s) - 36'(r_fyi);
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        cor_start = 1'b0;
        cor_angle = r_roll;
        mac_req = '0;
        mac_a = '0;
        mac_b = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_TRIG_R;
                end
            end
            S_TRIG_R: begin
                cor_start = 1'b1;
                n_state = S_TRIG_RW;
            end
            S_TRIG_RW: begin
                if (cor_done) begin
                    n_state = S_TRIG_P;
                end
            end
            S_TRIG_P: begin
                cor_start = 1'b1;
                cor_angle = r_pitch;
                n_state = S_TRIG_PW;
            end
            S_TRIG_PW: begin
                if (cor_done) begin
                    n_state = S_M_RP;
                end
            end
            S_M_RP: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_sr);
                mac_b = r_sp;
                n_ret = S_M_PR;
                n_state = S_WAIT;
            end
            S_M_PR: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_sp);
                mac_b = r_cr;
                n_ret = S_CX0;
                n_state = S_WAIT;
            end
            S_CX0: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_x);
                mac_b = r_cp;
                n_ret = S_CX1;
                n_state = S_WAIT;
            end
            S_CX1: begin
                mac_req = '{start: 1'b1, clr: 1'b0};
                mac_a = MAC_AW'(r_y);
                mac_b = r_srsp;
                n_ret = S_CX2;
                n_state = S_WAIT;
            end
            S_CX2: begin
                mac_req = '{start: 1'b1, clr: 1'b0};
                mac_a = MAC_AW'(r_z);
                mac_b = r_spcr;
                n_ret = S_CY0;
                n_state = S_WAIT;
            end
            S_CY0: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_y);
                mac_b = r_cr;
                n_ret = S_CY1;
                n_state = S_WAIT;
            end
            S_CY1: begin
                mac_req = '{start: 1'b1, clr: 1'b0};
                mac_a = -MAC_AW'(r_z);
                mac_b = r_sr;
                n_ret = S_VX;
                n_state = S_WAIT;
            end
            S_VX: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_comx) - MAC_AW'(r_prev_x);
                mac_b = MAC_BW'(r_inv_omega);
                n_ret = S_VY;
                n_state = S_WAIT;
            end
            S_VY: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_comy) - MAC_AW'(r_prev_y);
                mac_b = MAC_BW'(r_inv_omega);
                n_ret = S_CAPY;
                n_state = S_WAIT;
            end
            S_CAPY: begin
                n_state = S_FXY;
            end
            S_FXY: begin
                n_state = S_UX0;
            end
            S_UX0: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_fx);
                mac_b = r_cp;
                n_ret = S_UX1;
                n_state = S_WAIT;
            end
            S_UX1: begin
                mac_req = '{start: 1'b1, clr: 1'b0};
                mac_a = MAC_AW'(r_fy);
                mac_b = r_srsp;
                n_ret = S_UY;
                n_state = S_WAIT;
            end
            S_UY: begin
                mac_req = '{start: 1'b1, clr: 1'b1};
                mac_a = MAC_AW'(r_fy);
                mac_b = r_cr;
                n_ret = S_OUT;
                n_state = S_WAIT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_ovalid <= 1'b0;
            r_inv_omega <= INV_OMEGA_RST;
            r_fwd_bias <= '0;
            r_lat_base <= '0;
            r_lat_speed <= '0;
            r_hip <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_CAPY) begin
                r_prev_x <= r_comx;
                r_prev_y <= r_comy;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INV_OMEGA: r_inv_omega <= i_cfg_data[15:0];
                    REG_FWD_BIAS: r_fwd_bias <= i_cfg_data;
                    REG_LAT_BASE: r_lat_base <= i_cfg_data;
                    REG_LAT_SPEED: r_lat_speed <= i_cfg_data;
                    REG_HIP_OFFSET: r_hip <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers; product ones latch the product done before their state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fxi <= in_fx;
            r_fyi <= in_fy;
            r_roll <= s_axis_tdata[87:72];
            r_pitch <= s_axis_tdata[103:88];
            r_kind <= s_axis_tuser;
            r_x <= -26'(in_fx);
            r_y <= in_y;
            r_z <= -(26'(in_fz) + PELVIS_COM_OFFSET);
        end
        if (r_state == S_TRIG_RW && cor_done) begin
            r_cr <= cor_cos;
            r_sr <= cor_sin;
        end
        if (r_state == S_TRIG_PW && cor_done) begin
            r_cp <= cor_cos;
            r_sp <= cor_sin;
        end
        case (r_state)
            S_M_PR: r_srsp <= acc_r15[17:0];
            S_CX0: r_spcr <= acc_r15[17:0];
            S_CY0: r_comx <= sat24(36'(acc_r15));
            S_VX: r_comy <= sat24(36'(acc_r15));
            S_VY: r_capx <= 27'(r_comx) + acc_r16[26:0];
            S_CAPY: r_capy <= 27'(r_comy) + acc_r16[26:0];
            S_FXY: begin
                r_fx <= 30'(r_capx) - 30'(r_fwd_bias);
                r_fy <= 30'(r_capy) - 30'(lat_bias);
            end
            S_UY: r_ux <= sat24(36'(acc_r15) - 36'(r_fxi));
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_odata <= {sat24(uy_sum), r_ux};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the capture point step planner: table-driven and random requests.
`timescale 1ns / 100ps

module tb_top;
    import cpsp_pkg::*;

    localparam int N_RANDOM = 630;
    localparam int N_TABLE = 16;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [23:0]  i_cfg_data;

    typedef struct packed {
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [23:0] fz;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [1:0]         kind;
    } t_pose;

    typedef struct packed {
        logic signed [23:0] step_x;
        logic signed [23:0] step_y;
    } t_step;

    typedef struct {
        t_pose pose;
        logic  has_exp;
        t_step exp;
    } t_row;

    // planner state mirror
    longint unsigned m_inv_omega;
    longint m_fwd, m_lat_base, m_lat_speed, m_hip;
    longint m_prev_x, m_prev_y;

    t_step  step_q[$];
    t_row   rows[N_TABLE];
    bit     failed;
    bit     in_stall_phase;
    int     n_got;

    capture_point_step_planner uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #400ms;
        $display("Verification failed");
        $finish;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_sh(longint v, int s);
        return shr(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                          64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                          64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                          64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                          64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                          64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return t[i];
    endfunction

    task automatic sin_cos(input longint ang, output longint c, output longint sn);
        longint z, x, y, nx;
        z = ang * 65536;
        x = 652032874;
        y = 0;
        if (z > 1686629713) begin
            z -= 1686629713; x = 0; y = 652032874;
        end else if (z < -1686629713) begin
            z += 1686629713; x = 0; y = -652032874;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - shr(y, i); y = y + shr(x, i); z -= atan_tab(i);
            end else begin
                nx = x + shr(y, i); y = y - shr(x, i); z += atan_tab(i);
            end
            x = nx;
        end
        c = rnd_sh(x, 15);
        sn = rnd_sh(y, 15);
    endtask

    task automatic plan_step(input t_pose p, output t_step r);
        longint s, cr, sr, cp, sp, srsp, spcr, xx, yy, zz, cx, cy, kx, ky, ex, ey;
        s = (p.kind == KIND_RIGHT) ? 1 : ((p.kind == KIND_LEFT) ? -1 : 0);
        sin_cos(longint'(p.roll), cr, sr);
        sin_cos(longint'(p.pitch), cp, sp);
        srsp = rnd_sh(sr * sp, 15);
        spcr = rnd_sh(sp * cr, 15);
        xx = -longint'(p.fx);
        yy = -(longint'(p.fy) + s * (m_hip >>> 1));
        zz = -(longint'(p.fz) + 5120);
        cx = clip24(rnd_sh(cp * xx + srsp * yy + spcr * zz, 15));
        cy = clip24(rnd_sh(cr * yy - sr * zz, 15));
        kx = cx + rnd_sh((cx - m_prev_x) * longint'(m_inv_omega), 16);
        ky = cy + rnd_sh((cy - m_prev_y) * longint'(m_inv_omega), 16);
        m_prev_x = cx;
        m_prev_y = cy;
        ex = kx - m_fwd;
        ey = ky - s * (m_lat_base - s * m_lat_speed);
        r.step_x = 24'(clip24(rnd_sh(cp * ex + srsp * ey, 15) - longint'(p.fx)));
        r.step_y = 24'(clip24(rnd_sh(cr * ey, 15) + s * m_hip - longint'(p.fy)));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_INV_OMEGA:  m_inv_omega = val[15:0];
            REG_FWD_BIAS:   m_fwd = longint'($signed(val));
            REG_LAT_BASE:   m_lat_base = longint'($signed(val));
            REG_LAT_SPEED:  m_lat_speed = longint'($signed(val));
            REG_HIP_OFFSET: m_hip = longint'(val[22:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_pose(input t_pose p, input logic has_exp, input t_step e);
        t_step r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.pitch, p.roll, p.fz, p.fy, p.fx};
        s_axis_tuser <= p.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        plan_step(p, r);
        if (has_exp && r != e) begin
            $display("%0t table mismatch in mirror: exp %h act %h", $time, e, r);
            failed = 1'b1;
        end
        step_q.push_back(has_exp ? e : r);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        while (step_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_pose rand_pose(int mode);
        t_pose p;
        p.fx = $urandom;
        p.fy = $urandom;
        p.fz = $urandom;
        p.roll = $urandom;
        p.pitch = $urandom;
        p.kind = $urandom_range(0, 3);
        if (mode != 0) begin
            p.fx = 24'($signed($urandom_range(0, 80000)) - 40000);
            p.fy = 24'($signed($urandom_range(0, 80000)) - 40000);
            p.fz = 24'($signed($urandom_range(0, 40000)) - 120000);
            p.roll = 16'($signed($urandom_range(0, 8000)) - 4000);
            p.pitch = 16'($signed($urandom_range(0, 8000)) - 4000);
        end
        return p;
    endfunction

    // receiver: stall pattern plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (in_stall_phase) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                in_stall_phase = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: m_axis_tready <= 1'b0;
                1: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_got++;
            if (step_q.size() == 0) begin
                $display("%0t unexpected step: act %h", $time, m_axis_tdata);
                failed = 1'b1;
            end else begin
                t_step e;
                e = step_q.pop_front();
                if (m_axis_tdata[23:0] !== e.step_x)
                    $display("%0t step_x mismatch: exp %h act %h", $time, e.step_x,
                             m_axis_tdata[23:0]);
                if (m_axis_tdata[47:24] !== e.step_y)
                    $display("%0t step_y mismatch: exp %h act %h", $time, e.step_y,
                             m_axis_tdata[47:24]);
                if (m_axis_tdata !== {e.step_y, e.step_x}) failed = 1'b1;
            end
        end
    end

    initial begin
        t_step none;
        int burst;
        none = '0;
        failed = 1'b0;
        in_stall_phase = 1'b0;
        n_got = 0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_INV_OMEGA;
        i_cfg_data = '0;
        m_inv_omega = 9362;
        m_fwd = 0; m_lat_base = 0; m_lat_speed = 0; m_hip = 0;
        m_prev_x = 0; m_prev_y = 0;

        // pose at rest: fixed expectations after reset where they are plain
        rows[0] = '{'{24'sd0, 24'sd0, -24'sd5120, 16'sd0, 16'sd0, 2'd0}, 1'b1, none};
        rows[1] = '{'{24'sd0, 24'sd0, -24'sd5120, 16'sd0, 16'sd0, 2'd1}, 1'b1, none};
        rows[2] = '{'{24'sd8388607, 24'sd8388607, 24'sd8388607, 16'sd32767, 16'sd32767,
                      2'd1}, 1'b0, none};
        rows[3] = '{'{-24'sd8388608, -24'sd8388608, -24'sd8388608, -16'sd32768,
                      -16'sd32768, 2'd2}, 1'b0, none};
        rows[4] = '{'{24'sd8388607, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 2'd0}, 1'b0, none};
        rows[5] = '{'{-24'sd8388608, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 2'd0}, 1'b0, none};
        rows[6] = '{'{24'sd1000, 24'sd2000, -24'sd200000, 16'sd25736, 16'sd0, 2'd3}, 1'b0,
                    none};
        rows[7] = '{'{24'sd1000, 24'sd2000, -24'sd200000, -16'sd25736, 16'sd0, 2'd2}, 1'b0,
                    none};
        rows[8] = '{'{24'sd0, -24'sd3000, -24'sd200000, 16'sd0, 16'sd25736, 2'd1}, 1'b0,
                    none};
        rows[9] = '{'{24'sd0, -24'sd3000, -24'sd200000, 16'sd0, -16'sd25736, 2'd0}, 1'b0,
                    none};
        rows[10] = '{'{24'sd4000000, -24'sd4000000, 24'sd0, 16'sd20000, -16'sd20000, 2'd1},
                     1'b0, none};
        rows[11] = '{'{24'sd0, 24'sd0, -24'sd5120, 16'sd0, 16'sd0, 2'd0}, 1'b0, none};
        rows[12] = '{'{24'sd123456, -24'sd654321, -24'sd300000, 16'sd1000, -16'sd2000,
                       2'd2}, 1'b0, none};
        rows[13] = '{'{-24'sd123456, 24'sd654321, -24'sd300000, -16'sd1000, 16'sd2000,
                       2'd1}, 1'b0, none};
        rows[14] = '{'{24'sd0, 24'sd0, 24'sd8388607, 16'sd12867, 16'sd12867, 2'd3}, 1'b0,
                     none};
        rows[15] = '{'{24'sd0, 24'sd0, -24'sd5120, 16'sd0, 16'sd0, 2'd0}, 1'b0, none};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_TABLE; i++) begin
            if (i == 6) begin
                s_axis_tvalid <= 1'b0;
                drain();
                write_reg(REG_HIP_OFFSET, 24'h7FFFFF);
                write_reg(REG_LAT_BASE, 24'h7FFFFF);
                write_reg(REG_LAT_SPEED, 24'h800000);
                write_reg(REG_FWD_BIAS, 24'h800000);
                write_reg(REG_INV_OMEGA, 24'h00FFFF);
            end
            if (i == 11) begin
                s_axis_tvalid <= 1'b0;
                drain();
                write_reg(REG_INV_OMEGA, 24'h0);
                write_reg(REG_HIP_OFFSET, 24'd40000);
                write_reg(REG_LAT_BASE, 24'd3000);
                write_reg(REG_LAT_SPEED, -24'sd1500);
                write_reg(REG_FWD_BIAS, 24'd2500);
            end
            send_pose(rows[i].pose, rows[i].has_exp, rows[i].exp);
        end

        for (int ph = 0; ph < 4; ph++) begin
            s_axis_tvalid <= 1'b0;
            drain();
            case (ph)
                0: begin
                    write_reg(REG_INV_OMEGA, 24'd9362);
                    write_reg(REG_HIP_OFFSET, 24'd45000);
                    write_reg(REG_FWD_BIAS, 24'd0);
                end
                1: begin
                    write_reg(REG_INV_OMEGA, 24'($urandom));
                    write_reg(REG_FWD_BIAS, 24'($urandom));
                    write_reg(REG_LAT_BASE, 24'($urandom));
                    write_reg(REG_LAT_SPEED, 24'($urandom));
                    write_reg(REG_HIP_OFFSET, 24'($urandom));
                end
                2: begin
                    write_reg(REG_INV_OMEGA, 24'hFFFF);
                    write_reg(REG_HIP_OFFSET, 24'd0);
                    in_stall_phase = 1'b1;
                end
                default: begin
                    write_reg(REG_INV_OMEGA, 24'd20000);
                    write_reg(REG_LAT_BASE, -24'sd4000);
                    write_reg(REG_LAT_SPEED, 24'd2000);
                    write_reg(REG_FWD_BIAS, -24'sd1000);
                    write_reg(REG_HIP_OFFSET, 24'd50000);
                end
            endcase
            for (int n = 0; n < N_RANDOM / 4; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < N_RANDOM / 4; b++, n++)
                    send_pose(rand_pose($urandom_range(0, 3) != 0), 1'b0, none);
                if ($urandom_range(0, 2) != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 300)) @(posedge i_clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        drain();
        if (step_q.size() == 0 && !failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
